FILE: rtl/core/m4inv_pkg.sv
`timescale 1ns / 1ps
package m4inv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ELEM_W    = 32;
   localparam int OPND_W    = ELEM_W + 1;        // multiplier operand, signed
   localparam int PROD_W    = 65;                // kept product / 2x2 difference
   localparam int COF_W     = 128;               // stored cofactor, signed
   localparam int ACC_W     = 168;               // exact accumulator and divider width
   localparam int DQ_SH     = 4 * FRAC_BITS - 32; // det scale down to Q32.32
   localparam int Q_W       = 33;                // quotient bits incl. overflow bit
   localparam int STEP_W    = 6;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q_W - 1);
   localparam int CSR_AW    = 3;
   localparam logic [31:0] THR_RESET = 32'd4295;

   typedef enum logic [1:0] {
      XS_ELEM = 2'd0,
      XS_DLO  = 2'd1,
      XS_DHI  = 2'd2,
      XS_COF  = 2'd3
   } xsel_type;

   typedef enum logic [1:0] {
      DST_DSET = 2'd0,
      DST_DSUB = 2'd1,
      DST_ACC  = 2'd2
   } dst_type;

   typedef struct packed {
      logic       store_en;
      logic [3:0] store_addr;
      logic       rd_en;
      logic [3:0] xa;
      logic [3:0] yb;
      logic [3:0] cof_addr;
      logic       mul_en;
      xsel_type   xsel;
      logic       acc_en;
      dst_type    dst;
      logic [1:0] shift;
      logic       neg;
      logic       clr;
      logic       cof_wr;
      logic       fin_en;
      logic       div_ld;
      logic       div_step;
      logic       out_load;
      logic [3:0] out_index;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic singular;
   } status_type;

   // n-th index of 0..3 once index drop is taken out
   function automatic logic [1:0] skip_idx(input logic [1:0] drop, input logic [1:0] n);
      return (n >= drop) ? n + 2'd1 : n;
   endfunction

endpackage

FILE: rtl/core/matrix4_inverse_cofactor.sv
`timescale 1ns / 1ps
// 4x4 matrix inverse by adjugate over determinant, signed Q16.16 elements in, row-major.
// One element is taken per cycle; after the 16th the input stalls until the last result
// has been placed in the output register. Minors, cofactors and the row-0 determinant
// are exact, built on one shared 33x33 multiplier in operations of read, multiply and
// accumulate: 16 cofactors x 12 operations plus 16 for the determinant.
// Each result then goes through the bit-serial divider, skipped when the matrix is
// singular, and waits out any output stall. Results come out row-major with the
// determinant (Q32.32, saturated) and the singular flag on every transaction; a matrix
// with |det| at or below the threshold register yields zeros. Register 0 at byte
// address 0 is singular_threshold (reset 4295, Q32.32 units).
module matrix4_inverse_cofactor import m4inv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input transactions
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_element_value,
   // result transactions
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_inverse_value,
   output logic [3:0]        rsp_result_index,
   output logic [63:0]       rsp_determinant_value,
   output logic              rsp_singular_flag,
   output logic              rsp_last_flag,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cmd_type    cmd;
   status_type status;
   logic [31:0] thr_ff;

   // register 0 lives in the low word; the upper word reads zero
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         thr_ff <= pwdata;
      end
   end

   m4inv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   m4inv_dp u_dp (
      .clock             (clock),
      .cmd               (cmd),
      .status            (status),
      .threshold         (thr_ff),
      .element_value     (req_element_value),
      .inverse_value     (rsp_inverse_value),
      .result_index      (rsp_result_index),
      .determinant_value (rsp_determinant_value),
      .singular_flag     (rsp_singular_flag),
      .last_flag         (rsp_last_flag)
   );

`ifndef ASSERT_OFF
   // a singular matrix never produces a nonzero element
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular_flag |-> rsp_inverse_value == 32'd0)
      else $error("nonzero value on singular result");

   // last marker only on the final element
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_flag |-> rsp_result_index == 4'd15)
      else $error("last flag on wrong index");

   // results go out in index order within a matrix
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_flag ##1 rsp_valid && !$stable(rsp_result_index)
      |-> rsp_result_index == $past(rsp_result_index) + 4'd1)
      else $error("result index out of order");
`endif

endmodule

FILE: rtl/core/m4inv_ctrl.sv
`timescale 1ns / 1ps
module m4inv_ctrl import m4inv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [8:0] {
      S_LOAD = 9'b000000001,
      S_RD   = 9'b000000010,
      S_MUL  = 9'b000000100,
      S_ACC  = 9'b000001000,
      S_FIN  = 9'b000010000,
      S_DRD  = 9'b000100000,
      S_DLD  = 9'b001000000,
      S_DIV  = 9'b010000000,
      S_PUT  = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        load_cnt_ff, load_cnt_in;
   logic [3:0]        k_ff, k_in;
   logic [1:0]        t_ff, t_in;
   logic [1:0]        u_ff, u_in;
   logic              det_ph_ff, det_ph_in;
   logic [3:0]        res_ff, res_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              vld_ff, vld_in;

   logic [1:0] r, c, row0, row1, row2, c0, c1, c2;
   logic       put_ok;

   assign r    = k_ff[3:2];
   assign c    = k_ff[1:0];
   assign row0 = skip_idx(r, 2'd0);
   assign row1 = skip_idx(r, 2'd1);
   assign row2 = skip_idx(r, 2'd2);
   assign c0   = skip_idx(c, t_ff);
   assign c1   = skip_idx(c, (t_ff == 2'd0) ? 2'd1 : 2'd0);
   assign c2   = skip_idx(c, (t_ff == 2'd2) ? 2'd1 : 2'd2);

   assign put_ok    = !vld_ff || !rsp_stall;
   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = vld_ff;

   // micro-op decode
   always_comb begin
      cmd = '0;
      cmd.xsel = XS_ELEM;
      cmd.dst  = DST_ACC;
      if (!det_ph_ff) begin
         cmd.cof_addr = k_ff;
         cmd.neg      = (t_ff == 2'd1) ^ r[0] ^ c[0];
         case (u_ff)
            2'd0: begin
               cmd.xa  = {row1, c1};
               cmd.yb  = {row2, c2};
               cmd.dst = DST_DSET;
            end
            2'd1: begin
               cmd.xa  = {row1, c2};
               cmd.yb  = {row2, c1};
               cmd.dst = DST_DSUB;
            end
            2'd2: begin
               cmd.yb   = {row0, c0};
               cmd.xsel = XS_DLO;
               cmd.clr  = (t_ff == 2'd0);
            end
            default: begin
               cmd.yb     = {row0, c0};
               cmd.xsel   = XS_DHI;
               cmd.shift  = 2'd1;
               cmd.cof_wr = (state_ff == S_ACC) && (t_ff == 2'd2);
            end
         endcase
      end else begin
         cmd.cof_addr = {2'b00, k_ff[1:0]};
         cmd.yb       = {2'b00, k_ff[1:0]};
         cmd.xsel     = XS_COF;
         cmd.shift    = u_ff;
         cmd.clr      = (k_ff[1:0] == 2'd0) && (u_ff == 2'd0);
      end
      if (state_ff == S_DRD) cmd.cof_addr = {res_ff[1:0], res_ff[3:2]};
      cmd.store_en   = (state_ff == S_LOAD) && req_valid;
      cmd.store_addr = load_cnt_ff;
      cmd.rd_en      = (state_ff == S_RD) || (state_ff == S_DRD);
      cmd.mul_en     = (state_ff == S_MUL);
      cmd.acc_en     = (state_ff == S_ACC);
      cmd.fin_en     = (state_ff == S_FIN);
      cmd.div_ld     = (state_ff == S_DLD) && !status.singular;
      cmd.div_step   = (state_ff == S_DIV);
      cmd.out_load   = (state_ff == S_PUT) && put_ok;
      cmd.out_index  = res_ff;
      cmd.out_last   = (res_ff == 4'd15);
   end

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      k_in        = k_ff;
      t_in        = t_ff;
      u_in        = u_ff;
      det_ph_in   = det_ph_ff;
      res_in      = res_ff;
      step_in     = step_ff;
      vld_in      = vld_ff && rsp_stall;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               load_cnt_in = load_cnt_ff + 4'd1;
               if (load_cnt_ff == 4'd15) begin
                  state_in  = S_RD;
                  k_in      = 4'd0;
                  t_in      = 2'd0;
                  u_in      = 2'd0;
                  det_ph_in = 1'b0;
               end
            end
         end
         S_RD:  state_in = S_MUL;
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            state_in = S_RD;
            u_in     = u_ff + 2'd1;
            if (!det_ph_ff) begin
               if (u_ff == 2'd3) begin
                  t_in = t_ff + 2'd1;
                  if (t_ff == 2'd2) begin
                     t_in = 2'd0;
                     k_in = k_ff + 4'd1;
                     if (k_ff == 4'd15) det_ph_in = 1'b1;
                  end
               end
            end else if (u_ff == 2'd3) begin
               k_in = k_ff + 4'd1;
               if (k_ff[1:0] == 2'd3) state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_DRD;
            res_in   = 4'd0;
         end
         S_DRD: state_in = S_DLD;
         S_DLD: begin
            step_in  = '0;
            state_in = status.singular ? S_PUT : S_DIV;
         end
         S_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) state_in = S_PUT;
         end
         S_PUT: begin
            if (put_ok) begin
               vld_in   = 1'b1;
               res_in   = res_ff + 4'd1;
               state_in = (res_ff == 4'd15) ? S_LOAD : S_DRD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         load_cnt_ff <= 4'd0;
         k_ff        <= 4'd0;
         t_ff        <= 2'd0;
         u_ff        <= 2'd0;
         det_ph_ff   <= 1'b0;
         res_ff      <= 4'd0;
         step_ff     <= '0;
         vld_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         k_ff        <= k_in;
         t_ff        <= t_in;
         u_ff        <= u_in;
         det_ph_ff   <= det_ph_in;
         res_ff      <= res_in;
         step_ff     <= step_in;
         vld_ff      <= vld_in;
      end
   end

endmodule

FILE: rtl/core/m4inv_dp.sv
`timescale 1ns / 1ps
module m4inv_dp import m4inv_pkg::*; (
   input  logic               clock,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [31:0]        threshold,
   input  logic [ELEM_W-1:0]  element_value,
   output logic [31:0]        inverse_value,
   output logic [3:0]         result_index,
   output logic [63:0]        determinant_value,
   output logic               singular_flag,
   output logic               last_flag
);

   logic [ELEM_W-1:0]  mem_ff [16];
   logic [COF_W-1:0]   cof_mem_ff [16];
   logic [ELEM_W-1:0]  ea_ff, eb_ff;
   logic [COF_W-1:0]   cof_rd_ff;
   logic [PROD_W-1:0]  p_ff, d_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   mag_ff, r_ff, ds_ff;
   logic               det_neg_ff, sing_ff, qneg_ff;
   logic [63:0]        det_out_ff;
   logic [Q_W-1:0]     q_ff;
   logic [31:0]        oval_ff;
   logic [3:0]         oidx_ff;
   logic [63:0]        odet_ff;
   logic               osing_ff, olast_ff;

   logic signed [OPND_W-1:0]   mx, my;
   logic signed [2*OPND_W-1:0] prod;
   logic [ACC_W-1:0]           addend, acc_base;
   logic [ACC_W-1:0]           mag, limit, dq;
   logic                       dq_fits;
   logic [63:0]                det_out;
   logic [COF_W-1:0]           cof_abs;
   logic                       ge;
   logic [31:0]                qval;

   // element store and read registers
   always_ff @(posedge clock) begin
      if (cmd.store_en) mem_ff[cmd.store_addr] <= element_value;
      if (cmd.rd_en) begin
         ea_ff     <= mem_ff[cmd.xa];
         eb_ff     <= mem_ff[cmd.yb];
         cof_rd_ff <= cof_mem_ff[cmd.cof_addr];
      end
   end

   // shared 33x33 multiplier
   always_comb begin
      case (cmd.xsel)
         XS_ELEM: mx = {ea_ff[ELEM_W-1], ea_ff};
         XS_DLO:  mx = {1'b0, d_ff[31:0]};
         XS_DHI:  mx = d_ff[64:32];
         XS_COF: begin
            case (cmd.shift)
               2'd0:    mx = {1'b0, cof_rd_ff[31:0]};
               2'd1:    mx = {1'b0, cof_rd_ff[63:32]};
               2'd2:    mx = {1'b0, cof_rd_ff[95:64]};
               default: mx = {cof_rd_ff[COF_W-1], cof_rd_ff[127:96]};
            endcase
         end
         default: mx = '0;
      endcase
      my   = {eb_ff[ELEM_W-1], eb_ff};
      prod = mx * my;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) p_ff <= prod[PROD_W-1:0];
   end

   // accumulate, shifted by whole limbs
   always_comb begin
      addend   = {{(ACC_W-PROD_W){p_ff[PROD_W-1]}}, p_ff} << {cmd.shift, 5'b00000};
      acc_base = cmd.clr ? '0 : acc_ff;
      acc_in   = cmd.neg ? acc_base - addend : acc_base + addend;
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         case (cmd.dst)
            DST_DSET: d_ff   <= p_ff;
            DST_DSUB: d_ff   <= d_ff - p_ff;
            DST_ACC:  acc_ff <= acc_in;
            default:  d_ff   <= d_ff;
         endcase
      end
      if (cmd.cof_wr) cof_mem_ff[cmd.cof_addr] <= acc_in[COF_W-1:0];
   end

   // determinant wrap-up
   always_comb begin
      mag     = acc_ff[ACC_W-1] ? ACC_W'(0) - acc_ff : acc_ff;
      limit   = ACC_W'(threshold) << DQ_SH;
      dq      = ACC_W'($signed(acc_ff) >>> DQ_SH);
      dq_fits = (&dq[ACC_W-1:63]) || !(|dq[ACC_W-1:63]);
      if (dq_fits)             det_out = dq[63:0];
      else if (acc_ff[ACC_W-1]) det_out = 64'h8000_0000_0000_0000;
      else                     det_out = 64'h7FFF_FFFF_FFFF_FFFF;
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_en) begin
         mag_ff     <= mag;
         det_neg_ff <= acc_ff[ACC_W-1];
         sing_ff    <= (mag <= limit);
         det_out_ff <= det_out;
      end
   end

   assign status.singular = sing_ff;

   // restoring divider, one quotient bit a cycle
   // cofactor carries 3*FRAC_BITS, det 4*FRAC_BITS: scale the dividend up by 2*FRAC_BITS
   assign cof_abs = cof_rd_ff[COF_W-1] ? COF_W'(0) - cof_rd_ff : cof_rd_ff;
   assign ge      = (r_ff >= ds_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_ld) begin
         r_ff    <= ACC_W'(cof_abs) << (2 * FRAC_BITS);
         ds_ff   <= mag_ff << 32;
         q_ff    <= '0;
         qneg_ff <= cof_rd_ff[COF_W-1] ^ det_neg_ff;
      end else if (cmd.div_step) begin
         if (ge) r_ff <= r_ff - ds_ff;
         ds_ff <= ds_ff >> 1;
         q_ff  <= {q_ff[Q_W-2:0], ge};
      end
   end

   always_comb begin
      if (qneg_ff) qval = (q_ff > 33'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - q_ff[31:0];
      else         qval = (q_ff > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_ff[31:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         oval_ff  <= sing_ff ? 32'd0 : qval;
         oidx_ff  <= cmd.out_index;
         odet_ff  <= det_out_ff;
         osing_ff <= sing_ff;
         olast_ff <= cmd.out_last;
      end
   end

   assign inverse_value     = oval_ff;
   assign result_index      = oidx_ff;
   assign determinant_value = odet_ff;
   assign singular_flag     = osing_ff;
   assign last_flag         = olast_ff;

endmodule
